@@ src/kalman_box_tracker_defines.svh @@
// Assertion macros for the box tracker RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef KALMAN_BOX_TRACKER_DEFINES_SVH
`define KALMAN_BOX_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define KBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define KBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define KBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define KBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/kbt_pkg.sv @@
// Shared types, codes and helpers for the box tracker.
// No dependencies; used by every module of the block.
`default_nettype none
package kbt_pkg;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int STREAK_LIMIT_DEF = 3;
  localparam int NUM_LANES        = 4;

  // input op codes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_HIT     = 2'd2;
  localparam logic [1:0] OP_MISS    = 2'd3;

  // config register indexes
  localparam logic [2:0] CFG_MAX_LIFE  = 3'd0;
  localparam logic [2:0] CFG_DAMPING   = 3'd1;
  localparam logic [2:0] CFG_POS_Q     = 3'd2;
  localparam logic [2:0] CFG_SIZE_Q    = 3'd3;
  localparam logic [2:0] CFG_MOTION_QR = 3'd4;
  localparam logic [2:0] CFG_SIZE_QR   = 3'd5;
  localparam logic [2:0] CFG_POS_R     = 3'd6;
  localparam logic [2:0] CFG_SIZE_R    = 3'd7;

  // config reset values
  localparam logic [15:0] MAX_LIFE_RST  = 16'd30;
  localparam logic [16:0] DAMPING_RST   = 17'd52429;
  localparam logic [16:0] POS_Q_RST     = 17'd66;
  localparam logic [16:0] SIZE_Q_RST    = 17'd131;
  localparam logic [16:0] MOTION_QR_RST = 17'd66;
  localparam logic [16:0] SIZE_QR_RST   = 17'd655;
  localparam logic [19:0] POS_R_RST     = 20'd655;
  localparam logic [19:0] SIZE_R_RST    = 20'd6554;
  localparam logic [16:0] DAMP_ONE      = 17'd65536;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic signed [31:0] box_width;
    logic signed [31:0] box_height;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_left;
    logic signed [31:0] out_top;
    logic signed [31:0] out_width;
    logic signed [31:0] out_height;
    logic [15:0]        life_left;
    logic               expired;
    logic               healthy;
  } out_word_t;

  // command from the input handshake to each axis lane
  typedef struct packed {
    logic       go;
    logic [1:0] op;
  } lane_ctl_t;

  localparam logic signed [67:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [67:0] S32_MIN = -68'sd2147483648;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

@@ src/kbt_div.sv @@
// Radix-2 restoring divider: sat32((num << FRAC_BITS) / den), truncated toward zero.
// Depends on kbt_pkg; one quotient bit per cycle.
`default_nettype none
module kbt_div #(
  parameter int FRAC_BITS = kbt_pkg::FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire signed [31:0]  num,
  input  wire        [31:0]  den,
  output logic               busy,
  output logic signed [31:0] quo
);
  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [31:0]   rem_r;
  logic [DW-1:0] dvd_r;
  logic [31:0]   den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          neg_r;
  logic [31:0]   mag;
  logic [32:0]   trial;
  logic          fit;
  logic          ovf;

  assign mag   = num[31] ? (~num + 32'd1) : num;
  assign trial = {rem_r, dvd_r[DW-1]};
  assign fit   = trial >= {1'b0, den_r};

  // one bit per cycle, quotient shifts into the dividend register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
      rem_r  <= '0;
      dvd_r  <= {mag, {FRAC_BITS{1'b0}}};
      den_r  <= den;
      neg_r  <= num[31];
    end else if (busy_r) begin
      rem_r  <= fit ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      dvd_r  <= {dvd_r[DW-2:0], fit};
      cnt_r  <= cnt_r - CW'(1);
      busy_r <= (cnt_r != CW'(1));
    end
  end

  // sign and clamp
  always_comb begin
    if (neg_r) begin
      ovf = (|dvd_r[DW-1:32]) || (dvd_r[31] && (|dvd_r[30:0]));
      quo = ovf ? 32'sh80000000 : $signed(~dvd_r[31:0] + 32'd1);
    end else begin
      ovf = |dvd_r[DW-1:31];
      quo = ovf ? 32'sh7FFFFFFF : $signed(dvd_r[31:0]);
    end
  end

  assign busy = busy_r;
endmodule
`default_nettype wire

@@ src/kbt_lane.sv @@
// One axis of the tracker: value, rate and 2x2 covariance with a sequenced multiplier.
// Depends on kbt_pkg and kbt_div (two dividers for the gains).
`default_nettype none
module kbt_lane #(
  parameter int FRAC_BITS = kbt_pkg::FRAC_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire kbt_pkg::lane_ctl_t ctl,
  input  wire signed [31:0]      z,
  input  wire        [16:0]      d,
  input  wire        [16:0]      q,
  input  wire        [16:0]      qr,
  input  wire        [19:0]      r,
  output logic                   busy,
  output logic signed [31:0]     value
);
  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_DIV  = 2'd1;
  localparam logic [1:0] L_MUL  = 2'd2;
  localparam logic [1:0] L_ACC  = 2'd3;

  // multiply steps: predict then correct
  localparam logic [3:0] S_PRT = 4'd0;
  localparam logic [3:0] S_PCC = 4'd1;
  localparam logic [3:0] S_PC1 = 4'd2;
  localparam logic [3:0] S_PC2 = 4'd3;
  localparam logic [3:0] S_CV  = 4'd4;
  localparam logic [3:0] S_CR  = 4'd5;
  localparam logic [3:0] S_CA  = 4'd6;
  localparam logic [3:0] S_CC  = 4'd7;
  localparam logic [3:0] S_CB  = 4'd8;

  localparam logic [2:0] D_V  = 3'd0;
  localparam logic [2:0] D_RT = 3'd1;
  localparam logic [2:0] D_A  = 3'd2;
  localparam logic [2:0] D_B  = 3'd3;
  localparam logic [2:0] D_C  = 3'd4;
  localparam logic [2:0] D_T  = 3'd5;

  localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [66:0] RND_F = 67'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [66:0] RND_D = 67'sd1 <<< 15;

  logic [1:0]         st_r;
  logic [3:0]         stp_r;
  logic signed [31:0] v_r, rt_r, a_r, b_r, c_r, e_r;
  logic signed [65:0] prod_r;

  logic signed [33:0] s_sum;
  logic               s_pos;
  logic               div_go;
  logic               kv_busy, kr_busy;
  logic signed [31:0] kv, kr;

  logic signed [32:0] x_s, y_s;
  logic               sh16, neg;
  logic signed [31:0] base;
  logic [2:0]         dest;
  logic signed [32:0] bc_sum;
  logic signed [32:0] d_s;
  logic signed [66:0] rnd;
  logic signed [66:0] shf;
  logic signed [31:0] m_rs;
  logic signed [33:0] acc;
  logic signed [31:0] wb;
  logic signed [34:0] pa;
  logic signed [31:0] e_new;

  // innovation variance and gain dividers
  assign s_sum  = 34'(a_r) + 34'($signed({1'b0, r}));
  assign s_pos  = !s_sum[33] && (s_sum != 34'sd0);
  assign div_go = ctl.go && (ctl.op == kbt_pkg::OP_HIT) && (st_r == L_IDLE) && s_pos;
  assign e_new  = kbt_pkg::sat32(68'(33'(z) - 33'(v_r)));

  kbt_div #(.FRAC_BITS(FRAC_BITS)) u_div_kv (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(a_r), .den(s_sum[31:0]),
    .busy(kv_busy), .quo(kv)
  );
  kbt_div #(.FRAC_BITS(FRAC_BITS)) u_div_kr (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(b_r), .den(s_sum[31:0]),
    .busy(kr_busy), .quo(kr)
  );

  assign bc_sum = 33'(b_r) + 33'(c_r);
  assign d_s    = 33'($signed({1'b0, d}));
  assign pa     = 35'(a_r) + (35'(b_r) <<< 1) + 35'(c_r) + 35'($signed({1'b0, q}));

  // step decoder: operands, rounding, accumulate base and target
  always_comb begin
    x_s  = 33'(rt_r);
    y_s  = d_s;
    sh16 = 1'b1;
    neg  = 1'b0;
    base = '0;
    dest = D_RT;
    unique case (stp_r)
      S_PRT: begin
        x_s = 33'(rt_r); dest = D_RT;
      end
      S_PCC: begin
        x_s = bc_sum; dest = D_B;
      end
      S_PC1: begin
        x_s = 33'(c_r); dest = D_T;
      end
      S_PC2: begin
        x_s = 33'(e_r); base = $signed({15'd0, qr}); dest = D_C;
      end
      S_CV: begin
        x_s = 33'(kv); y_s = 33'(e_r); sh16 = 1'b0; base = v_r; dest = D_V;
      end
      S_CR: begin
        x_s = 33'(kr); y_s = 33'(e_r); sh16 = 1'b0; base = rt_r; dest = D_RT;
      end
      S_CA: begin
        x_s = 33'(kv); y_s = 33'(a_r); sh16 = 1'b0; base = a_r; neg = 1'b1; dest = D_A;
      end
      S_CC: begin
        x_s = 33'(kr); y_s = 33'(b_r); sh16 = 1'b0; base = c_r; neg = 1'b1; dest = D_C;
      end
      S_CB: begin
        x_s = 33'(kv); y_s = 33'(b_r); sh16 = 1'b0; base = b_r; neg = 1'b1; dest = D_B;
      end
      default: begin
        dest = D_RT;
      end
    endcase
  end

  // round the registered product, then add it to or subtract it from the base
  always_comb begin
    rnd  = 67'(prod_r) + (sh16 ? RND_D : RND_F);
    shf  = sh16 ? (rnd >>> 16) : (rnd >>> FRAC_BITS);
    m_rs = kbt_pkg::sat32(68'(shf));
    acc  = neg ? (34'(base) - 34'(m_rs)) : (34'(base) + 34'(m_rs));
    wb   = kbt_pkg::sat32(68'(acc));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= L_IDLE;
      stp_r <= S_PRT;
      v_r   <= '0;
      rt_r  <= '0;
      a_r   <= ONE;
      b_r   <= '0;
      c_r   <= ONE;
      e_r   <= '0;
    end else begin
      unique case (st_r)
        L_IDLE: begin
          if (ctl.go) begin
            case (ctl.op)
              kbt_pkg::OP_START: begin
                v_r  <= z;
                rt_r <= '0;
                a_r  <= ONE;
                b_r  <= '0;
                c_r  <= ONE;
              end
              kbt_pkg::OP_PREDICT: begin
                v_r   <= kbt_pkg::sat32(68'(33'(v_r) + 33'(rt_r)));
                a_r   <= kbt_pkg::sat32(68'(pa));
                stp_r <= S_PRT;
                st_r  <= L_MUL;
              end
              kbt_pkg::OP_HIT: begin
                if (s_pos) begin
                  e_r   <= e_new;
                  stp_r <= S_CV;
                  st_r  <= L_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        L_DIV: begin
          if (!kv_busy && !kr_busy) begin
            st_r <= L_MUL;
          end
        end
        L_MUL: begin
          prod_r <= x_s * y_s;
          st_r   <= L_ACC;
        end
        L_ACC: begin
          case (dest)
            D_V:     v_r  <= wb;
            D_RT:    rt_r <= wb;
            D_A:     a_r  <= wb;
            D_B:     b_r  <= wb;
            D_C:     c_r  <= wb;
            default: e_r  <= wb;
          endcase
          if (stp_r == S_PC2 || stp_r == S_CB) begin
            st_r <= L_IDLE;
          end else begin
            stp_r <= stp_r + 4'd1;
            st_r  <= L_MUL;
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign busy  = (st_r != L_IDLE);
  assign value = v_r;
endmodule
`default_nettype wire

@@ src/kalman_box_tracker.sv @@
// Box tracker sequencing, from the accepting edge to out_valid:
// start and miss go straight to the output register; predict runs four damped multiplies
// per lane; hit runs the gain dividers, one handoff and five multiplies, lanes in
// parallel, or goes straight to the output register when no lane has a positive S.
// One word in flight, next word taken once the result loads into the output register, even while it waits.
// Synchronous active-low reset: covariances to identity, states, life, streak and config registers.
`default_nettype none
`include "kalman_box_tracker_defines.svh"
module kalman_box_tracker #(
  parameter int FRAC_BITS    = kbt_pkg::FRAC_BITS_DEF,
  parameter int STREAK_LIMIT = kbt_pkg::STREAK_LIMIT_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire kbt_pkg::in_word_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output kbt_pkg::out_word_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [2:0]           cfg_index,
  input  wire [19:0]          cfg_data
);
  localparam int SW = $clog2(STREAK_LIMIT + 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [15:0] max_life_r;
  logic [16:0] damping_r, pos_q_r, size_q_r, motion_qr_r, size_qr_r;
  logic [19:0] pos_r_r, size_r_r;

  logic [0:0]         st_r;
  logic [1:0]         op_r;
  logic signed [31:0] box_r   [kbt_pkg::NUM_LANES];
  logic signed [31:0] shown_r [kbt_pkg::NUM_LANES];
  logic [SW-1:0]      streak_r, streak_nxt;
  logic [15:0]        life_r, life_nxt;
  logic               expired_r, expired_nxt;
  logic               out_valid_r;
  kbt_pkg::out_word_t out_r;

  logic               accept;
  logic               finish;
  kbt_pkg::lane_ctl_t lane_ctl;
  logic signed [31:0] z     [kbt_pkg::NUM_LANES];
  logic signed [31:0] lval  [kbt_pkg::NUM_LANES];
  logic               lbusy [kbt_pkg::NUM_LANES];
  logic               busy_any;
  logic signed [31:0] shown_nxt [kbt_pkg::NUM_LANES];
  logic signed [31:0] w_fl, h_fl;
  logic [16:0]        life_sum;

  // config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_life_r  <= kbt_pkg::MAX_LIFE_RST;
      damping_r   <= kbt_pkg::DAMPING_RST;
      pos_q_r     <= kbt_pkg::POS_Q_RST;
      size_q_r    <= kbt_pkg::SIZE_Q_RST;
      motion_qr_r <= kbt_pkg::MOTION_QR_RST;
      size_qr_r   <= kbt_pkg::SIZE_QR_RST;
      pos_r_r     <= kbt_pkg::POS_R_RST;
      size_r_r    <= kbt_pkg::SIZE_R_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kbt_pkg::CFG_MAX_LIFE:  max_life_r  <= cfg_data[15:0];
        kbt_pkg::CFG_DAMPING:   damping_r   <= cfg_data[16:0];
        kbt_pkg::CFG_POS_Q:     pos_q_r     <= cfg_data[16:0];
        kbt_pkg::CFG_SIZE_Q:    size_q_r    <= cfg_data[16:0];
        kbt_pkg::CFG_MOTION_QR: motion_qr_r <= cfg_data[16:0];
        kbt_pkg::CFG_SIZE_QR:   size_qr_r   <= cfg_data[16:0];
        kbt_pkg::CFG_POS_R:     pos_r_r     <= cfg_data;
        default:                size_r_r    <= cfg_data;
      endcase
    end
  end

  assign in_ready = (st_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // measurement from the given box
  assign z[0] = kbt_pkg::sat32(68'(33'(in_data.box_left) + 33'(in_data.box_width >>> 1)));
  assign z[1] = kbt_pkg::sat32(68'(33'(in_data.box_top) + 33'(in_data.box_height)));
  assign z[2] = in_data.box_width;
  assign z[3] = in_data.box_height;

  assign lane_ctl.go = accept;
  assign lane_ctl.op = in_data.op;

  // axis lanes: x and y undamped, width and height damped
  for (genvar g = 0; g < kbt_pkg::NUM_LANES; g++) begin : g_lane
    if (g < 2) begin : g_pos
      kbt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .z(z[g]),
        .d(kbt_pkg::DAMP_ONE), .q(pos_q_r), .qr(motion_qr_r), .r(pos_r_r),
        .busy(lbusy[g]), .value(lval[g])
      );
    end else begin : g_size
      kbt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .z(z[g]),
        .d(damping_r), .q(size_q_r), .qr(size_qr_r), .r(size_r_r),
        .busy(lbusy[g]), .value(lval[g])
      );
    end
  end

  assign busy_any = lbusy[0] || lbusy[1] || lbusy[2] || lbusy[3];

  // streak and life, settled at accept
  always_comb begin
    streak_nxt  = streak_r;
    life_nxt    = life_r;
    expired_nxt = 1'b0;
    life_sum    = '0;
    case (in_data.op)
      kbt_pkg::OP_START: begin
        streak_nxt = '0;
        life_nxt   = max_life_r;
      end
      kbt_pkg::OP_HIT: begin
        streak_nxt = (streak_r == SW'(STREAK_LIMIT)) ? streak_r : streak_r + SW'(1);
        life_sum   = {1'b0, life_r} + (17'd1 << streak_nxt);
        life_nxt   = (life_sum > {1'b0, max_life_r}) ? max_life_r : life_sum[15:0];
      end
      kbt_pkg::OP_MISS: begin
        streak_nxt  = '0;
        life_nxt    = (life_r != 16'd0) ? life_r - 16'd1 : 16'd0;
        expired_nxt = (life_nxt == 16'd0);
      end
      default: begin
      end
    endcase
  end

  // merge: shown box from lanes on predict, kept on miss, else from the given box
  assign w_fl = (lval[2] > ONE) ? lval[2] : ONE;
  assign h_fl = (lval[3] > ONE) ? lval[3] : ONE;
  always_comb begin
    for (int i = 0; i < kbt_pkg::NUM_LANES; i++) begin
      shown_nxt[i] = shown_r[i];
    end
    case (op_r)
      kbt_pkg::OP_PREDICT: begin
        shown_nxt[0] = kbt_pkg::sat32(68'(33'(lval[0]) - 33'(w_fl >>> 1)));
        shown_nxt[1] = kbt_pkg::sat32(68'(33'(lval[1]) - 33'(h_fl)));
        shown_nxt[2] = w_fl;
        shown_nxt[3] = h_fl;
      end
      kbt_pkg::OP_MISS: begin
      end
      default: begin
        for (int i = 0; i < kbt_pkg::NUM_LANES; i++) begin
          shown_nxt[i] = box_r[i];
        end
      end
    endcase
  end

  assign finish = (st_r == ST_RUN) && !busy_any && (!out_valid_r || out_ready);

  // control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      streak_r    <= '0;
      life_r      <= '0;
      expired_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < kbt_pkg::NUM_LANES; i++) begin
        shown_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        st_r      <= ST_RUN;
        op_r      <= in_data.op;
        streak_r  <= streak_nxt;
        life_r    <= life_nxt;
        expired_r <= expired_nxt;
        box_r[0]  <= in_data.box_left;
        box_r[1]  <= in_data.box_top;
        box_r[2]  <= in_data.box_width;
        box_r[3]  <= in_data.box_height;
      end
      if (finish) begin
        st_r        <= ST_IDLE;
        out_valid_r <= 1'b1;
        for (int i = 0; i < kbt_pkg::NUM_LANES; i++) begin
          shown_r[i] <= shown_nxt[i];
        end
        out_r.out_left   <= shown_nxt[0];
        out_r.out_top    <= shown_nxt[1];
        out_r.out_width  <= shown_nxt[2];
        out_r.out_height <= shown_nxt[3];
        out_r.life_left  <= life_r;
        out_r.expired    <= expired_r;
        out_r.healthy    <= (life_r != 16'd0);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `KBT_ASSERT_IMPL(a_ready_lanes_idle, clk, rst_n, in_ready, !busy_any)
  `KBT_ASSERT_NEXT(a_accept_runs, clk, rst_n, accept, st_r == ST_RUN)
  `KBT_ASSERT_IMPL(a_healthy_life, clk, rst_n, out_valid, out_data.healthy == (out_data.life_left != 16'd0))
  `KBT_ASSERT_IMPL(a_expired_zero, clk, rst_n, out_valid && out_data.expired, out_data.life_left == 16'd0)
endmodule
`default_nettype wire

@@ tb/tb_kalman_box_tracker.sv @@
// Self-checking testbench for the kalman_box_tracker block: directed and random
// track sequences against an in-bench fixed-point predictor, across register settings.
// Depends on kbt_pkg and the kalman_box_tracker RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_kalman_box_tracker;
  localparam int ONE_Q = 65536;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  kbt_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  kbt_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  kalman_box_tracker i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // words waiting to be sent, and track boxes waiting to come back
  kbt_pkg::in_word_t  pending_words[$];
  kbt_pkg::out_word_t expected_boxes[$];
  int error_count = 0;
  int words_sent = 0;
  int boxes_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  logic in_taken = 1'b0;

  // tracker model state
  int unsigned lim_life, damping, pos_q, size_q, motion_qr, size_qr, pos_r, size_r;
  int axis_val[4], axis_rate[4], var_val[4], cov_x[4], var_rt[4], shown[4];
  int unsigned streak, life_cnt;

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int qmul(int a, int b);
    return sat((longint'(a) * longint'(b) + 32768) >>> 16);
  endfunction

  function automatic int dmul(longint v, longint d);
    return sat((v * d + 32768) >>> 16);
  endfunction

  function automatic int qdiv(int n, longint s);
    return sat((longint'(n) * 65536) / s);
  endfunction

  function automatic void measure_box(kbt_pkg::in_word_t w, output int z[4]);
    z[0] = sat(longint'(w.box_left) + (longint'(w.box_width) >>> 1));
    z[1] = sat(longint'(w.box_top) + longint'(w.box_height));
    z[2] = w.box_width;
    z[3] = w.box_height;
  endfunction

  function automatic void predict_axis(int i, longint d, longint q, longint qr);
    longint a, b, c;
    a = var_val[i]; b = cov_x[i]; c = var_rt[i];
    axis_val[i]  = sat(longint'(axis_val[i]) + axis_rate[i]);
    axis_rate[i] = dmul(axis_rate[i], d);
    var_val[i]   = sat(a + 2 * b + c + q);
    cov_x[i]     = dmul(b + c, d);
    var_rt[i]    = sat(longint'(dmul(dmul(c, d), d)) + qr);
  endfunction

  function automatic void correct_axis(int i, int z, longint r);
    int a, b, c, kv, kr, e;
    longint s;
    a = var_val[i]; b = cov_x[i]; c = var_rt[i];
    s = longint'(a) + r;
    if (s <= 0) return;  // no gain: axis left alone
    kv = qdiv(a, s);
    kr = qdiv(b, s);
    e = sat(longint'(z) - axis_val[i]);
    axis_val[i]  = sat(longint'(axis_val[i]) + qmul(kv, e));
    axis_rate[i] = sat(longint'(axis_rate[i]) + qmul(kr, e));
    var_val[i]   = sat(longint'(a) - qmul(kv, a));
    cov_x[i]     = sat(longint'(b) - qmul(kv, b));
    var_rt[i]    = sat(longint'(c) - qmul(kr, b));
  endfunction

  function automatic void tracker_reset();
    lim_life = 30; damping = 52429; pos_q = 66; size_q = 131;
    motion_qr = 66; size_qr = 655; pos_r = 655; size_r = 6554;
    for (int i = 0; i < 4; i++) begin
      axis_val[i] = 0; axis_rate[i] = 0; var_val[i] = ONE_Q;
      cov_x[i] = 0; var_rt[i] = ONE_Q; shown[i] = 0;
    end
    streak = 0; life_cnt = 0;
  endfunction

  function automatic void tracker_cfg(logic [2:0] idx, logic [19:0] v);
    case (idx)
      kbt_pkg::CFG_MAX_LIFE:  lim_life  = v[15:0];
      kbt_pkg::CFG_DAMPING:   damping   = v[16:0];
      kbt_pkg::CFG_POS_Q:     pos_q     = v[16:0];
      kbt_pkg::CFG_SIZE_Q:    size_q    = v[16:0];
      kbt_pkg::CFG_MOTION_QR: motion_qr = v[16:0];
      kbt_pkg::CFG_SIZE_QR:   size_qr   = v[16:0];
      kbt_pkg::CFG_POS_R:     pos_r     = v;
      default:                size_r    = v;
    endcase
  endfunction

  // advance the tracker by one word and return the box it shows
  function automatic kbt_pkg::out_word_t track_step(kbt_pkg::in_word_t w);
    kbt_pkg::out_word_t r;
    int z[4];
    int wd, ht;
    int unsigned lf;
    logic gone;
    gone = 1'b0;
    case (w.op)
      kbt_pkg::OP_START: begin
        measure_box(w, z);
        for (int i = 0; i < 4; i++) begin
          axis_val[i] = z[i]; axis_rate[i] = 0; var_val[i] = ONE_Q;
          cov_x[i] = 0; var_rt[i] = ONE_Q;
        end
        shown = '{w.box_left, w.box_top, w.box_width, w.box_height};
        life_cnt = lim_life;
        streak = 0;
      end
      kbt_pkg::OP_PREDICT: begin
        predict_axis(0, 65536, pos_q, motion_qr);
        predict_axis(1, 65536, pos_q, motion_qr);
        predict_axis(2, damping, size_q, size_qr);
        predict_axis(3, damping, size_q, size_qr);
        wd = axis_val[2] > ONE_Q ? axis_val[2] : ONE_Q;
        ht = axis_val[3] > ONE_Q ? axis_val[3] : ONE_Q;
        shown[0] = sat(longint'(axis_val[0]) - (longint'(wd) >>> 1));
        shown[1] = sat(longint'(axis_val[1]) - ht);
        shown[2] = wd;
        shown[3] = ht;
      end
      kbt_pkg::OP_HIT: begin
        measure_box(w, z);
        correct_axis(0, z[0], pos_r);
        correct_axis(1, z[1], pos_r);
        correct_axis(2, z[2], size_r);
        correct_axis(3, z[3], size_r);
        shown = '{w.box_left, w.box_top, w.box_width, w.box_height};
        streak = (streak + 1 > kbt_pkg::STREAK_LIMIT_DEF) ? kbt_pkg::STREAK_LIMIT_DEF
                                                          : streak + 1;
        lf = life_cnt + (32'd1 << streak);
        life_cnt = (lf > lim_life) ? lim_life : lf;
      end
      default: begin
        streak = 0;
        if (life_cnt > 0) life_cnt--;
        gone = (life_cnt == 0);
      end
    endcase
    r.out_left = shown[0];
    r.out_top = shown[1];
    r.out_width = shown[2];
    r.out_height = shown[3];
    r.life_left = life_cnt[15:0];
    r.expired = gone;
    r.healthy = (life_cnt > 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // accepted words feed the model, accepted results are checked
  always @(posedge clk) begin
    kbt_pkg::out_word_t exp_w;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker_cfg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        expected_boxes.push_back(track_step(in_data));
        words_sent++;
      end
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_boxes.size() == 0) begin
          $display("%0t ns: unexpected result word %h", $time, out_data);
          error_count++;
        end else begin
          exp_w = expected_boxes.pop_front();
          check_field("out_left", exp_w.out_left, out_data.out_left);
          check_field("out_top", exp_w.out_top, out_data.out_top);
          check_field("out_width", exp_w.out_width, out_data.out_width);
          check_field("out_height", exp_w.out_height, out_data.out_height);
          check_field("life_left", exp_w.life_left, out_data.life_left);
          check_field("expired", exp_w.expired, out_data.expired);
          check_field("healthy", exp_w.healthy, out_data.healthy);
          boxes_checked++;
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with long hold-offs on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = 600;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [19:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_boxes.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_all(logic [19:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
  endtask

  function automatic void add_word(logic [1:0] op, int l, int t, int w, int h);
    kbt_pkg::in_word_t x;
    x.op = op; x.box_left = l; x.box_top = t; x.box_width = w; x.box_height = h;
    pending_words.push_back(x);
  endfunction

  // a random detection near the given box, or anywhere now and then
  function automatic void add_near(logic [1:0] op, int l, int t, int w, int h);
    if ($urandom_range(19) == 0)
      add_word(op, $urandom, $urandom, $urandom, $urandom);
    else
      add_word(op, l + $signed($urandom_range(1 << 20)) - (1 << 19),
               t + $signed($urandom_range(1 << 20)) - (1 << 19),
               w + $signed($urandom_range(1 << 19)) - (1 << 18),
               h + $signed($urandom_range(1 << 19)) - (1 << 18));
  endfunction

  // well-formed tracks with random content plus some noise words
  task automatic add_tracks(int n);
    int l, t, w, h, k, sel;
    k = 0;
    while (k < n) begin
      l = $signed($urandom_range(1 << 27)) - (1 << 26);
      t = $signed($urandom_range(1 << 27)) - (1 << 26);
      w = $urandom_range(1 << 24);
      h = $urandom_range(1 << 24);
      add_near(kbt_pkg::OP_START, l, t, w, h);
      k++;
      repeat ($urandom_range(40, 5)) begin
        sel = $urandom_range(99);
        if (sel < 40) add_word(kbt_pkg::OP_PREDICT, $urandom, $urandom, $urandom, $urandom);
        else if (sel < 75) add_near(kbt_pkg::OP_HIT, l, t, w, h);
        else if (sel < 92) add_word(kbt_pkg::OP_MISS, $urandom, $urandom, $urandom, $urandom);
        else add_word(2'($urandom), $urandom, $urandom, $urandom, $urandom);
        k++;
      end
    end
  endtask

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    tracker_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: life run-out, streak saturation, extreme and odd boxes
    write_reg(kbt_pkg::CFG_MAX_LIFE, 20'd3);
    add_word(kbt_pkg::OP_START, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    repeat (4) add_word(kbt_pkg::OP_MISS, 0, 0, 0, 0);
    add_word(kbt_pkg::OP_START, 100 << 16, 50 << 16, 40 << 16, 80 << 16);
    add_word(kbt_pkg::OP_PREDICT, 0, 0, 0, 0);
    repeat (4) add_word(kbt_pkg::OP_HIT, 102 << 16, 51 << 16, 41 << 16, 79 << 16);
    add_word(kbt_pkg::OP_PREDICT, 0, 0, 0, 0);
    add_word(kbt_pkg::OP_HIT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_word(kbt_pkg::OP_PREDICT, 0, 0, 0, 0);
    add_word(kbt_pkg::OP_START, 32'h80000000, 32'h7FFFFFFF, -(3 << 16) - 1, -5);
    add_word(kbt_pkg::OP_PREDICT, 0, 0, 0, 0);
    add_word(kbt_pkg::OP_HIT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    add_word(kbt_pkg::OP_MISS, 0, 0, 0, 0);
    add_word(kbt_pkg::OP_PREDICT, 0, 0, 0, 0);
    drain();

    // random phases over register settings and idling patterns
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_all('{20'd30, 20'd52429, 20'd66, 20'd131, 20'd66, 20'd655, 20'd655, 20'd6554});
        1: write_all('{20'd1, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0});
        2: write_all('{20'd65535, 20'd65536, 20'd65536, 20'd65536, 20'd65536, 20'd65536,
                       20'd655360, 20'd655360});
        3: write_all('{20'd0, 20'h1FFFF, 20'h1FFFF, 20'd1, 20'h1FFFF, 20'd1, 20'hFFFFF, 20'd1});
        default: begin
          logic [19:0] v[8];
          v[0] = $urandom_range(65535, 1);
          for (int i = 1; i < 6; i++) v[i] = $urandom_range(65536);
          v[6] = $urandom_range(655360);
          v[7] = $urandom_range(655360);
          write_all(v);
        end
      endcase
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 46 : 29) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 46 : 29) : 0;
      if (ph == 4) hold_requests++;
      add_tracks(270);
      drain();
    end

    $display("Covered %0d words and %0d checked track boxes over 8 register settings,",
             words_sent, boxes_checked);
    $display("with sender idling, receiver stalls and a long output hold-off.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
